// ----- rtl/placement_fragment_table_unit_defines.svh -----
// Assertion macros for the placement fragment table unit.
// Used by the modules that carry concurrent assertions; no other dependency.
`ifndef PLACEMENT_FRAGMENT_TABLE_UNIT_DEFINES_SVH
`define PLACEMENT_FRAGMENT_TABLE_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PFT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define PFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/pft_pkg.sv -----
// Shared types and constants of the placement fragment table unit.
// No dependencies; used by every module of the unit.
package pft_pkg;
   localparam int TableEntries = 12;
   localparam int ReqDataWidth = 96;
   localparam int RspDataWidth = 256;

   typedef struct packed {
      logic [7:0]  payload_hi;
      logic [63:0] payload_lo;
      logic [7:0]  frag_type;
      logic [3:0]  frag_length;
      logic [7:0]  generation;
   } req_type;

   typedef struct packed {
      logic [63:0] auxiliary;
      logic [23:0] angles;
      logic [47:0] coordinates;
      logic [63:0] attributes;
      logic        partial;
      logic [31:0] revision;
      logic [15:0] item_id;
      logic [1:0]  change;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_OTHER   = 2'd1,
      STATUS_BAD     = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CHANGE_NONE   = 2'd0,
      CHANGE_REMOVE = 2'd1,
      CHANGE_UPDATE = 2'd2
   } change_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_WRITE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      FR_HEADER = 2'd0,
      FR_ATTR   = 2'd1,
      FR_XFORM  = 2'd2,
      FR_AUX    = 2'd3
   } frag_type_e_type;

   // Work queued from front end to back end.
   typedef struct packed {
      logic        is_begin;    // generation changed: clear table
      logic        complete;    // record complete with nonzero id
      logic [1:0]  status;
      logic        partial;
      logic [15:0] id;
      logic [63:0] attr;
      logic [47:0] coord;
      logic [23:0] ang;
      logic [63:0] aux;
      logic        has_tf;
   } job_type;

   function automatic logic [3:0] frag_len(input logic [1:0] t);
      case (t)
         FR_HEADER: frag_len = 4'd6;
         FR_ATTR:   frag_len = 4'd6;
         FR_XFORM:  frag_len = 4'd10;
         FR_AUX:    frag_len = 4'd9;
         default:   frag_len = 4'd0;
      endcase
   endfunction
endpackage

// ----- rtl/placement_fragment_table_unit.sv -----
// Top level of the placement fragment table unit.
// Depends on pft_pkg, pft_front, pft_queue and pft_back.
//
// The unit takes one item per request (a generation begin or a message fragment) and
// returns exactly one result item for each. The front end checks and assembles fragments
// combinationally; a two-entry queue hands the work to the back end, which scans the id
// table one entry a cycle. A result that completes a record with a nonzero id passes
// through the sequential id search and the decide and write states before it is emitted;
// any other item goes from idle straight to emit. The table is held in flip-flops with
// per-entry valid bits, so reset or a new generation empties it at once.
module placement_fragment_table_unit #(
   parameter int TABLE_ENTRIES = pft_pkg::TableEntries
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // bits 7:0 generation, 11:8 frag_length, 19:12 frag_type, 83:20 payload_lo,
   // 91:84 payload_hi, 95:92 zero
   input  logic [95:0]  req_tdata,
   // bit 0 kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // bits 1:0 status, 3:2 change, 19:4 item_id, 51:20 revision, 52 partial,
   // 116:53 attributes, 164:117 coordinates, 188:165 angles, 252:189 auxiliary, 255:253 zero
   output logic [255:0] rsp_tdata
);
   pft_pkg::req_type req;
   pft_pkg::job_type fj, bj;
   pft_pkg::rsp_type rsp;
   logic fv, fr, bv, br;

   assign req = pft_pkg::req_type'(req_tdata[91:0]);
   assign rsp_tdata = {3'd0, rsp};

   pft_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_kind(req_tuser),
      .in_req(req), .job_valid(fv), .job_ready(fr), .job(fj)
   );

   pft_queue u_queue (
      .clock, .reset, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
      .rd_valid(bv), .rd_ready(br), .rd_data(bj)
   );

   pft_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock, .reset, .job_valid(bv), .job_ready(br), .job(bj),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp)
   );
endmodule

// ----- rtl/pft_front.sv -----
// Front end: checks fragments and assembles records.
// Depends on pft_pkg.
module pft_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_kind,
   input  pft_pkg::req_type  in_req,
   output logic              job_valid,
   input  logic              job_ready,
   output pft_pkg::job_type  job
);
   logic [7:0]  gen_ff, gen_in;
   logic [1:0]  exp_ff, exp_in;
   logic        asm_ff, asm_in;
   logic [15:0] id_ff, id_in;
   logic [63:0] attr_ff, attr_in;
   logic [47:0] coord_ff, coord_in;
   logic [23:0] ang_ff, ang_in;
   logic [63:0] aux_ff, aux_in;
   logic        tf_ff, tf_in;
   logic        fire;
   logic [7:0]  b1;
   logic [63:0] lo;

   assign in_ready  = job_ready;
   assign job_valid = in_valid;
   assign fire      = in_valid & job_ready;
   assign lo        = in_req.payload_lo;
   assign b1        = lo[7:0];

   always_comb begin
      gen_in = gen_ff; exp_in = exp_ff; asm_in = asm_ff; id_in = id_ff;
      attr_in = attr_ff; coord_in = coord_ff; ang_in = ang_ff;
      aux_in = aux_ff; tf_in = tf_ff;
      job = '0;
      job.status = pft_pkg::STATUS_OK;
      if (!in_kind) begin
         if (in_req.generation != gen_ff) begin
            job.is_begin = 1'b1;
            gen_in = in_req.generation;
            exp_in = '0; asm_in = 1'b0; id_in = '0; attr_in = '0;
            coord_in = '0; ang_in = '0; aux_in = '0; tf_in = 1'b0;
         end
      end else if (in_req.generation != gen_ff) begin
         job.status = pft_pkg::STATUS_OTHER;
      end else if (in_req.frag_length == 4'd0 || in_req.frag_type > 8'd3
                   || in_req.frag_length != pft_pkg::frag_len(in_req.frag_type[1:0])) begin
         job.status = pft_pkg::STATUS_BAD;
         exp_in = '0; asm_in = 1'b0; id_in = '0; attr_in = '0;
         coord_in = '0; ang_in = '0; aux_in = '0; tf_in = 1'b0;
      end else if (in_req.frag_type[1:0] == pft_pkg::FR_HEADER) begin
         coord_in = '0; ang_in = '0; aux_in = '0; tf_in = 1'b0;
         if ((lo[23:8] == 16'd0 && b1 != 8'd0) || b1[3:0] > 4'd5) begin
            job.status = pft_pkg::STATUS_BAD;
            exp_in = '0; asm_in = 1'b0; id_in = '0; attr_in = '0;
         end else begin
            id_in = lo[23:8];
            attr_in = {40'd0, lo[39:24], b1};
            exp_in = pft_pkg::FR_ATTR; asm_in = 1'b1;
         end
      end else if (in_req.frag_type[1:0] != exp_ff) begin
         job.status = pft_pkg::STATUS_BAD;
         exp_in = '0; asm_in = 1'b0; id_in = '0; attr_in = '0;
         coord_in = '0; ang_in = '0; aux_in = '0; tf_in = 1'b0;
      end else begin
         job.id = id_ff; job.coord = coord_ff; job.ang = ang_ff;
         job.aux = aux_ff; job.has_tf = tf_ff; job.attr = attr_ff;
         if (in_req.frag_type[1:0] == pft_pkg::FR_ATTR) begin
            job.attr = attr_ff | {lo[39:32], lo[31:16], lo[15:8], lo[7:0], 24'd0};
            attr_in = job.attr;
         end else if (in_req.frag_type[1:0] == pft_pkg::FR_XFORM) begin
            coord_in = lo[47:0];
            ang_in = {in_req.payload_hi, lo[63:48]};
            tf_in = 1'b1;
         end else begin
            job.aux = lo;
         end
         if (in_req.frag_type[1:0] == pft_pkg::FR_ATTR && job.attr[3:0] > 4'd3) begin
            exp_in = pft_pkg::FR_XFORM;
         end else if (in_req.frag_type[1:0] == pft_pkg::FR_XFORM) begin
            exp_in = pft_pkg::FR_AUX;
         end else begin
            job.complete = (id_ff != 16'd0);
            exp_in = '0; asm_in = 1'b0; id_in = '0; attr_in = '0;
            coord_in = '0; ang_in = '0; aux_in = '0; tf_in = 1'b0;
         end
      end
      job.partial = asm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= '0; exp_ff <= '0; asm_ff <= 1'b0; id_ff <= '0; attr_ff <= '0;
         coord_ff <= '0; ang_ff <= '0; aux_ff <= '0; tf_ff <= 1'b0;
      end else if (fire) begin
         gen_ff <= gen_in; exp_ff <= exp_in; asm_ff <= asm_in; id_ff <= id_in;
         attr_ff <= attr_in; coord_ff <= coord_in; ang_ff <= ang_in;
         aux_ff <= aux_in; tf_ff <= tf_in;
      end
   end
endmodule

// ----- rtl/pft_queue.sv -----
// Two-entry queue carrying jobs from front end to back end.
// Depends on pft_pkg.
`include "placement_fragment_table_unit_defines.svh"
module pft_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  pft_pkg::job_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output pft_pkg::job_type rd_data
);
   pft_pkg::job_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;
   assign wp_in    = wp_ff ^ push;
   assign rp_in    = rp_ff ^ pop;
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

   `PFT_ASSERT_IMPL(a_q_no_overflow, clock, reset, cnt_ff == 2'd2, !push, "queue overflow")
   `PFT_ASSERT_NEXT(a_q_count, clock, reset, push && !pop && cnt_ff == 2'd0, cnt_ff == 2'd1,
      "queue count wrong")
   `PFT_ASSERT_IMPL(a_q_range, clock, reset, 1'b1, cnt_ff != 2'd3, "queue count out of range")
endmodule

// ----- rtl/pft_back.sv -----
// Back end: for a completed record searches the entry table and applies it; emits a result for every job.
// Depends on pft_pkg.
`include "placement_fragment_table_unit_defines.svh"
module pft_back #(
   parameter int TABLE_ENTRIES = pft_pkg::TableEntries
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  pft_pkg::job_type job,
   output logic             out_valid,
   input  logic             out_ready,
   output pft_pkg::rsp_type out_rsp
);
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   pft_pkg::state_type state_ff, state_in;
   pft_pkg::job_type   job_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [15:0] eid_ff   [TABLE_ENTRIES];
   logic [63:0] eattr_ff [TABLE_ENTRIES];
   logic [47:0] ecoord_ff[TABLE_ENTRIES];
   logic [23:0] eang_ff  [TABLE_ENTRIES];
   logic [63:0] eaux_ff  [TABLE_ENTRIES];
   logic [CW-1:0] idx_ff;
   logic [IW-1:0] idx;
   logic        hit_ff, free_found_ff;
   logic [IW-1:0] slot_ff, free_ff;
   logic [31:0] rev_ff;
   pft_pkg::rsp_type rsp_ff;
   pft_pkg::rsp_type rsp_start;
   logic        take, do_write, do_remove, full;
   logic [IW-1:0] wslot;
   logic [47:0] ncoord;
   logic [23:0] nang;
   logic [63:0] naux;
   logic        removal;

   assign idx = idx_ff[IW-1:0];
   assign out_valid = (state_ff == pft_pkg::ST_EMIT);
   assign out_rsp   = rsp_ff;
   assign take      = job_valid & job_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pft_pkg::ST_IDLE:   if (job_valid) begin
            state_in = job.complete ? pft_pkg::ST_SEARCH : pft_pkg::ST_EMIT;
         end
         pft_pkg::ST_SEARCH: if (idx_ff == CW'(TABLE_ENTRIES - 1)) begin
            state_in = pft_pkg::ST_DECIDE;
         end
         pft_pkg::ST_DECIDE: state_in = pft_pkg::ST_WRITE;
         pft_pkg::ST_WRITE:  state_in = pft_pkg::ST_EMIT;
         pft_pkg::ST_EMIT:   if (out_ready) begin
            state_in = pft_pkg::ST_IDLE;
         end
         default:            state_in = pft_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      job_ready = (state_ff == pft_pkg::ST_IDLE);
      rsp_start = '0;
      rsp_start.status   = job.status;
      rsp_start.partial  = job.partial;
      rsp_start.revision = job.is_begin ? rev_ff + 32'd1 : rev_ff;
      removal = job_ff.attr[3:0] == 4'd1 || job_ff.attr[3:0] == 4'd2
                || job_ff.attr[7:5] == 3'd5 || job_ff.attr[7:5] == 3'd0;
      ncoord = job_ff.has_tf ? job_ff.coord : ecoord_ff[slot_ff];
      nang   = job_ff.has_tf ? job_ff.ang   : eang_ff[slot_ff];
      naux   = job_ff.has_tf ? job_ff.aux   : eaux_ff[slot_ff];
      do_remove = (state_ff == pft_pkg::ST_WRITE) && removal && hit_ff;
      full = 1'b0;
      do_write = 1'b0;
      wslot = hit_ff ? slot_ff : free_ff;
      if (state_ff == pft_pkg::ST_WRITE && !removal && (hit_ff || job_ff.has_tf)) begin
         if (hit_ff && eattr_ff[slot_ff] == job_ff.attr && ecoord_ff[slot_ff] == ncoord
             && eang_ff[slot_ff] == nang && eaux_ff[slot_ff] == naux) begin
            do_write = 1'b0;
         end else if (!hit_ff && !free_found_ff) begin
            full = 1'b1;
         end else begin
            do_write = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pft_pkg::ST_IDLE;
         valid_ff <= '0;
         rev_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (take && job.is_begin) begin
            valid_ff <= '0;
            rev_ff   <= rev_ff + 32'd1;
         end
         if (do_remove) begin
            valid_ff[slot_ff] <= 1'b0;
            rev_ff <= rev_ff + 32'd1;
         end
         if (do_write) begin
            valid_ff[wslot] <= 1'b1;
            rev_ff <= rev_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job;
         idx_ff <= '0;
         hit_ff <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_ff <= rsp_start;
      end
      if (state_ff == pft_pkg::ST_SEARCH) begin
         idx_ff <= idx_ff + CW'(1);
         if (valid_ff[idx]) begin
            if (!hit_ff && eid_ff[idx] == job_ff.id) begin
               hit_ff <= 1'b1; slot_ff <= idx;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1; free_ff <= idx;
         end
      end
      if (do_remove) begin
         rsp_ff.change <= pft_pkg::CHANGE_REMOVE;
         rsp_ff.item_id <= eid_ff[slot_ff];
         rsp_ff.attributes <= eattr_ff[slot_ff];
         rsp_ff.coordinates <= ecoord_ff[slot_ff];
         rsp_ff.angles <= eang_ff[slot_ff];
         rsp_ff.auxiliary <= eaux_ff[slot_ff];
         rsp_ff.revision <= rev_ff + 32'd1;
      end
      if (full) begin
         rsp_ff.status <= pft_pkg::STATUS_FULL;
      end
      if (do_write) begin
         eid_ff[wslot] <= job_ff.id;
         eattr_ff[wslot] <= job_ff.attr;
         ecoord_ff[wslot] <= ncoord;
         eang_ff[wslot] <= nang;
         eaux_ff[wslot] <= naux;
         rsp_ff.change <= pft_pkg::CHANGE_UPDATE;
         rsp_ff.item_id <= job_ff.id;
         rsp_ff.attributes <= job_ff.attr;
         rsp_ff.coordinates <= ncoord;
         rsp_ff.angles <= nang;
         rsp_ff.auxiliary <= naux;
         rsp_ff.revision <= rev_ff + 32'd1;
      end
   end

   `PFT_ASSERT_IMPL(a_b_excl, clock, reset, 1'b1, !(do_write && do_remove),
      "remove and write together")
   `PFT_ASSERT_NEXT(a_b_rev, clock, reset, do_write, rev_ff == $past(rev_ff) + 32'd1,
      "revision not advanced")
   `PFT_ASSERT_IMPL(a_b_take_idle, clock, reset, take, state_ff == pft_pkg::ST_IDLE,
      "job taken while busy")
endmodule

// ----- test/placement_fragment_table_unit_checker.sv -----
// Checker for the placement fragment table unit: watches both streams, predicts each result.
// Depends on pft_pkg for the result layout and the status and change codes.
`timescale 1ns / 100ps

module placement_fragment_table_unit_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [95:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [255:0] rsp_tdata,
   output int           mismatch_count,
   output int           pending_count,
   output int           result_count
);
   localparam int Entries = pft_pkg::TableEntries;
   localparam logic [3:0] FragBytes [4] = '{4'd6, 4'd6, 4'd10, 4'd9};

   // Shadow copy of the unit's state.
   logic [7:0]  gen_now;
   logic [31:0] rev_now;
   logic [1:0]  next_frag;
   logic        building;
   logic [15:0] bld_id;
   logic [63:0] bld_attr;
   logic [47:0] bld_coord;
   logic [23:0] bld_ang;
   logic [63:0] bld_aux;
   logic        bld_tf;
   logic        slot_used  [Entries];
   logic [15:0] slot_id    [Entries];
   logic [63:0] slot_attr  [Entries];
   logic [47:0] slot_coord [Entries];
   logic [23:0] slot_ang   [Entries];
   logic [63:0] slot_aux   [Entries];

   pft_pkg::rsp_type expected_results [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   task automatic drop_record();
      next_frag = pft_pkg::FR_HEADER;
      building  = 1'b0;
      bld_id    = '0;
      bld_attr  = '0;
      bld_coord = '0;
      bld_ang   = '0;
      bld_aux   = '0;
      bld_tf    = 1'b0;
   endtask

   task automatic empty_table();
      for (int i = 0; i < Entries; i++) slot_used[i] = 1'b0;
   endtask

   task automatic show_slot(inout pft_pkg::rsp_type r, input int s,
                            input pft_pkg::change_type c);
      r.change      = c;
      r.item_id     = slot_id[s];
      r.attributes  = slot_attr[s];
      r.coordinates = slot_coord[s];
      r.angles      = slot_ang[s];
      r.auxiliary   = slot_aux[s];
   endtask

   // Applies a finished record to the table and returns its status.
   task automatic store_record(inout pft_pkg::rsp_type r, output pft_pkg::status_type st_out);
      logic [15:0] id;
      logic [63:0] attr;
      logic [47:0] coord;
      logic [23:0] ang;
      logic [63:0] aux;
      logic        tf;
      logic [3:0]  op;
      logic [2:0]  st;
      int          hit;
      int          spare;
      id = bld_id; attr = bld_attr; coord = bld_coord; ang = bld_ang; aux = bld_aux;
      tf = bld_tf;
      hit = -1;
      spare = -1;
      st_out = pft_pkg::STATUS_OK;
      drop_record();
      if (id == 0) return;
      op = attr[3:0];
      st = attr[7:5];
      for (int i = 0; i < Entries; i++) begin
         if (slot_used[i]) begin
            if (hit < 0 && slot_id[i] == id) hit = i;
         end else if (spare < 0) begin
            spare = i;
         end
      end
      if (op == 1 || op == 2 || st == 5 || st == 0) begin
         if (hit >= 0) begin
            show_slot(r, hit, pft_pkg::CHANGE_REMOVE);
            slot_used[hit] = 1'b0;
            rev_now++;
         end
         return;
      end
      if (hit < 0 && !tf) return;
      if (!tf) begin
         coord = slot_coord[hit];
         ang   = slot_ang[hit];
         aux   = slot_aux[hit];
      end
      if (hit >= 0 && slot_attr[hit] == attr && slot_coord[hit] == coord &&
          slot_ang[hit] == ang && slot_aux[hit] == aux) return;
      if (hit < 0) begin
         if (spare < 0) begin
            st_out = pft_pkg::STATUS_FULL;
            return;
         end
         hit = spare;
      end
      slot_used[hit]  = 1'b1;
      slot_id[hit]    = id;
      slot_attr[hit]  = attr;
      slot_coord[hit] = coord;
      slot_ang[hit]   = ang;
      slot_aux[hit]   = aux;
      rev_now++;
      show_slot(r, hit, pft_pkg::CHANGE_UPDATE);
   endtask

   task automatic take_fragment(input logic [3:0] len, input logic [7:0] typ,
                                input logic [63:0] lo, input logic [7:0] hi,
                                inout pft_pkg::rsp_type r,
                                output pft_pkg::status_type st_out);
      st_out = pft_pkg::STATUS_OK;
      if (len == 0 || typ > 3 || len != FragBytes[typ[1:0]]) begin
         drop_record();
         st_out = pft_pkg::STATUS_BAD;
         return;
      end
      if (typ[1:0] == pft_pkg::FR_HEADER) begin
         drop_record();
         if ((lo[23:8] == 0 && lo[7:0] != 0) || lo[3:0] > 5) begin
            st_out = pft_pkg::STATUS_BAD;
            return;
         end
         bld_id    = lo[23:8];
         bld_attr  = {40'd0, lo[39:24], lo[7:0]};
         next_frag = pft_pkg::FR_ATTR;
         building  = 1'b1;
         return;
      end
      if (typ[1:0] != next_frag) begin
         drop_record();
         st_out = pft_pkg::STATUS_BAD;
         return;
      end
      case (typ[1:0])
         pft_pkg::FR_ATTR: begin
            bld_attr[31:24] = lo[7:0];
            bld_attr[39:32] = lo[15:8];
            bld_attr[55:40] = lo[31:16];
            bld_attr[63:56] = lo[39:32];
            if (bld_attr[3:0] > 3) begin
               next_frag = pft_pkg::FR_XFORM;
               return;
            end
         end
         pft_pkg::FR_XFORM: begin
            bld_coord = lo[47:0];
            bld_ang   = {hi, lo[63:48]};
            bld_tf    = 1'b1;
            next_frag = pft_pkg::FR_AUX;
            return;
         end
         default: bld_aux = lo;
      endcase
      store_record(r, st_out);
   endtask

   task automatic predict_item(input logic kind, input pft_pkg::req_type q,
                               output pft_pkg::rsp_type r);
      pft_pkg::status_type st;
      r = '0;
      st = pft_pkg::STATUS_OK;
      if (!kind) begin
         if (q.generation != gen_now) begin
            drop_record();
            empty_table();
            gen_now = q.generation;
            rev_now++;
         end
      end else if (q.generation != gen_now) begin
         st = pft_pkg::STATUS_OTHER;
      end else begin
         take_fragment(q.frag_length, q.frag_type, q.payload_lo, q.payload_hi, r, st);
      end
      r.status   = st;
      r.revision = rev_now;
      r.partial  = building;
   endtask

   always @(posedge clock) begin
      pft_pkg::rsp_type got;
      pft_pkg::rsp_type want;
      pft_pkg::rsp_type fresh;
      if (reset) begin
         gen_now = '0;
         rev_now = '0;
         drop_record();
         empty_table();
         expected_results.delete();
         mismatch_count = 0;
         result_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = pft_pkg::rsp_type'(rsp_tdata[$bits(pft_pkg::rsp_type)-1:0]);
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 64'(got.revision), 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.change != want.change)
                  report_mismatch("change", 64'(got.change), 64'(want.change));
               if (got.item_id != want.item_id)
                  report_mismatch("item_id", 64'(got.item_id), 64'(want.item_id));
               if (got.revision != want.revision)
                  report_mismatch("revision", 64'(got.revision), 64'(want.revision));
               if (got.partial != want.partial)
                  report_mismatch("partial", 64'(got.partial), 64'(want.partial));
               if (got.attributes != want.attributes)
                  report_mismatch("attributes", got.attributes, want.attributes);
               if (got.coordinates != want.coordinates)
                  report_mismatch("coordinates", 64'(got.coordinates),
                                  64'(want.coordinates));
               if (got.angles != want.angles)
                  report_mismatch("angles", 64'(got.angles), 64'(want.angles));
               if (got.auxiliary != want.auxiliary)
                  report_mismatch("auxiliary", got.auxiliary, want.auxiliary);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_item(req_tuser,
                         pft_pkg::req_type'(req_tdata[$bits(pft_pkg::req_type)-1:0]), fresh);
            expected_results.push_back(fresh);
         end
      end
      pending_count = expected_results.size();
   end
endmodule

// ----- test/placement_fragment_table_unit_tb.sv -----
// Top of the placement fragment table unit testbench: clock, reset, stimulus and verdict.
// Depends on pft_pkg, the unit itself and placement_fragment_table_unit_checker.
`timescale 1ns / 100ps

module placement_fragment_table_unit_tb;
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [255:0] rsp_tdata;

   int mismatch_count;
   int pending_count;
   int result_count;
   int items_sent = 0;
   int burst_left = 0;
   int leftover_fails = 0;
   int records_sent = 0;
   logic [7:0] cur_gen = 8'd0;

   always #5 clock = ~clock;

   placement_fragment_table_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   placement_fragment_table_unit_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .mismatch_count(mismatch_count), .pending_count(pending_count),
      .result_count(result_count)
   );

   // The receiver switches at random between three moods: always ready, mostly ready or
   // mostly stalled, so that back pressure holds results in the emit state and fills the queue.
   int ready_mode = 0;
   int ready_tick = 0;
   always @(negedge clock) begin
      if (ready_tick == 0) ready_mode = $urandom_range(0, 2);
      ready_tick = (ready_tick + 1) % 64;
      case (ready_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Presents one item and returns once it has been taken. The sender works in
   // bursts; between bursts valid may drop for a random gap.
   task automatic send_item(input logic kind, input logic [7:0] gen, input logic [3:0] len,
                            input logic [7:0] typ, input logic [63:0] lo, input logic [7:0] hi);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tuser  = kind;
      req_tdata  = {4'd0, hi, lo, typ, len, gen};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_frag(input logic [7:0] typ, input logic [3:0] len,
                            input logic [63:0] lo, input logic [7:0] hi);
      send_item(1'b1, cur_gen, len, typ, lo, hi);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // A well-formed record: header, attributes, and transform plus auxiliary when the
   // operation asks for them. Stops early after 'cut' fragments when cut is below four.
   task automatic send_record(input logic [15:0] id, input logic [7:0] opst, input int cut);
      logic [63:0] hdr;
      hdr = rand64();
      hdr[23:0] = {id, opst};
      send_frag(8'(pft_pkg::FR_HEADER), 4'd6, hdr, 8'($urandom()));
      if (cut == 1) return;
      send_frag(8'(pft_pkg::FR_ATTR), 4'd6, rand64(), 8'($urandom()));
      if (opst[3:0] <= 3 || cut == 2) return;
      send_frag(8'(pft_pkg::FR_XFORM), 4'd10, rand64(), 8'($urandom()));
      if (cut == 3) return;
      send_frag(8'(pft_pkg::FR_AUX), 4'd9, rand64(), 8'($urandom()));
      records_sent++;
   endtask

   // Header byte with an operation that keeps or inserts and a state that is not a removal.
   function automatic logic [7:0] keep_opst(input logic [3:0] op);
      logic [2:0] st;
      st = 3'd5;
      while (st == 3'd0 || st == 3'd5) st = 3'($urandom_range(0, 7));
      return {st, 1'($urandom_range(0, 1)), op};
   endfunction

   // A mostly-inserting random record over a small id pool so that the table fills.
   task automatic send_random_record(input int cut);
      logic [15:0] id;
      logic [7:0]  opst;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)       id = 16'd0;
      else if (pick < 8)  id = 16'($urandom());
      else                id = 16'($urandom_range(1, 16));
      pick = $urandom_range(0, 99);
      if (pick < 15)      opst = {3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                  4'($urandom_range(1, 2))};
      else if (pick < 25) opst = {3'($urandom_range(0, 1) ? 0 : 5),
                                  1'($urandom_range(0, 1)), 4'($urandom_range(0, 5))};
      else if (pick < 45) opst = keep_opst($urandom_range(0, 1) ? 4'd0 : 4'd3);
      else                opst = keep_opst(4'($urandom_range(4, 5)));
      if (id == 0 && $urandom_range(0, 1)) opst = 8'd0;
      send_record(id, opst, cut);
   endtask

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int pick;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: generation handling, each malformed case, and the table paths.
      cur_gen = 8'd1;
      send_item(1'b0, 8'd1, 4'd0, 8'd0, 64'd0, 8'd0);        // new generation
      send_item(1'b0, 8'd1, 4'd15, 8'hFF, '1, 8'hFF);        // same generation again
      send_item(1'b1, 8'hFF, 4'd6, 8'd0, 64'h0000_0000_0001_0304, 8'd0); // other generation
      send_frag(8'd0, 4'd0, '1, 8'hFF);                      // zero length
      send_frag(8'hFF, 4'd6, '1, 8'hFF);                     // type out of range
      send_frag(8'(pft_pkg::FR_XFORM), 4'd9, 64'd0, 8'd0);   // wrong length for type
      send_frag(8'(pft_pkg::FR_HEADER), 4'd6, 64'h0000_0000_0000_0004, 8'd0); // zero id
      send_frag(8'(pft_pkg::FR_HEADER), 4'd6, 64'h0000_0000_0001_0006, 8'd0); // op above five
      send_frag(8'(pft_pkg::FR_ATTR), 4'd6, '1, 8'd0);       // attributes with no header
      send_record(16'h0001, keep_opst(4'd4), 1);             // header then a fresh header
      send_record(16'hFFFF, keep_opst(4'd5), 4);             // insert with transform
      send_record(16'hFFFF, keep_opst(4'd3), 4);             // update without transform
      send_record(16'h0002, keep_opst(4'd3), 4);             // no transform, unknown id
      send_record(16'h0000, 8'd0, 4);                        // zero id record
      send_record(16'hFFFF, 8'h21, 4);                       // removal
      send_record(16'h0003, keep_opst(4'd4), 2);             // transform skipped
      send_frag(8'(pft_pkg::FR_AUX), 4'd9, '1, 8'd0);

      // Random part.
      while (items_sent < 920) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_random_record(4);
         end else if (pick < 78) begin
            send_random_record($urandom_range(1, 3));
         end else if (pick < 92) begin
            send_item(1'b1, $urandom_range(0, 3) ? cur_gen : 8'($urandom()),
                      4'($urandom_range(0, 15)), $urandom_range(0, 1)
                      ? 8'($urandom_range(0, 3)) : 8'($urandom()), rand64(), 8'($urandom()));
         end else if (pick < 98) begin
            send_item(1'b0, cur_gen, 4'($urandom()), 8'($urandom()), rand64(),
                      8'($urandom()));
         end else begin
            cur_gen = 8'($urandom());
            send_item(1'b0, cur_gen, 4'($urandom()), 8'($urandom()), rand64(),
                      8'($urandom()));
         end
         // Around halfway, let the unit drain completely before going on.
         if (items_sent >= 450 && items_sent < 460) begin
            req_tvalid = 1'b0;
            while (pending_count != 0) @(negedge clock);
            burst_left = 0;
         end
      end
      req_tvalid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (pending_count != 0) begin
         $display("results still missing: %0d", pending_count);
         leftover_fails++;
      end
      $display("sent %0d items including %0d full records, checked %0d results",
                items_sent, records_sent, result_count);
      if (mismatch_count == 0 && leftover_fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
